### sv/swm_pkg.sv
// Shared types, constants and the tree select function for the sliding window maximum block.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int DATA_W            = 32;
  localparam int WIN_SIZE_W        = 7;
  localparam int WINDOW_MAX_DEF    = 64;
  localparam logic [WIN_SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd3;

  // One candidate slot: the sample it holds and whether it is still a candidate.
  typedef struct packed {
    logic                     alive;
    logic signed [DATA_W-1:0] value;
  } node_t;

  // Per-cell control: shift the chain by one beat, and drop the old contents.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // The older side wins whenever it still holds a candidate.
  function automatic node_t node_pick(input node_t newer, input node_t older);
    node_t res;
    res       = older.alive ? older : newer;
    res.alive = newer.alive | older.alive;
    return res;
  endfunction

endpackage

### sv/sliding_window_max_top.sv
// Top level of the sliding window maximum block: cell chain, selection tree and handshakes.
`timescale 1ns / 1ps

// Running maximum over the last window_size signed 32-bit samples. Every accepted
// beat shifts a chain of WINDOW_MAX cells by one place, so cell k always holds the
// sample of age k; each cell decides on its own whether its sample is still a
// candidate (inside the window and not beaten by a strictly larger newer sample).
// A registered selection tree of LVLS = clog2(WINDOW_MAX) levels then picks the
// oldest live candidate, which is the window maximum. The block therefore takes no
// new sample until the tree root has settled and the result, if any, is loaded; the
// wait is set by the depth of the tree, and a result beat that is still stalled at
// the output holds the block back only when the next result is ready.
// The output register lets the next sample enter while a result waits. A sequence
// starts with first_sample or after a beat with last_sample; results appear once
// the sequence holds at least window_size samples, and the result of the
// last_sample beat carries last_result. window_size of zero acts as one, values
// above WINDOW_MAX act as WINDOW_MAX. Write window_size only while the block is idle.
module sliding_window_max_top #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swm_pkg::DATA_W-1:0]   in_sample,
  input  logic                                in_first_sample,
  input  logic                                in_last_sample,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swm_pkg::DATA_W-1:0]   out_window_max,
  output logic                                out_last_result,
  // Window size register.
  input  logic                                cfg_we,
  input  logic [swm_pkg::WIN_SIZE_W-1:0]      cfg_wdata
);

  localparam int LVLS   = (WINDOW_MAX <= 2) ? 1 : $clog2(WINDOW_MAX);
  localparam int LEAVES = 1 << LVLS;
  localparam int CNT_W  = $clog2(LVLS + 1);
  localparam int FILL_W = (WINDOW_MAX <= 1) ? 1 : $clog2(WINDOW_MAX + 1);
  localparam int CW     = (FILL_W > swm_pkg::WIN_SIZE_W) ? FILL_W : swm_pkg::WIN_SIZE_W;

  localparam logic [CW-1:0]     WMAX_CW   = CW'(WINDOW_MAX);
  localparam logic [CW-1:0]     ONE_CW    = CW'(1);
  localparam logic [FILL_W-1:0] WMAX_FILL = FILL_W'(WINDOW_MAX);
  localparam logic [FILL_W-1:0] ONE_FILL  = FILL_W'(1);
  localparam logic [CNT_W-1:0]  LVLS_CNT  = CNT_W'(LVLS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                              state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [swm_pkg::WIN_SIZE_W-1:0]    window_size_r;
  logic [FILL_W-1:0]                 fill_r, fill_nxt;
  logic                              start_pending_r;
  logic                              pend_emit_r, pend_last_r;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [swm_pkg::DATA_W-1:0] out_window_max_r;
  logic                              out_last_result_r;

  logic                              accept;
  logic                              clear;
  logic                              finish;
  logic                              out_load;
  logic [CW-1:0]                     win_raw;
  logic [CW-1:0]                     w_eff;
  swm_pkg::cell_ctl_t                ctl_head;
  swm_pkg::cell_ctl_t                ctl_body;
  swm_pkg::node_t                    cell_q [WINDOW_MAX];
  swm_pkg::node_t                    leaf   [LEAVES];
  swm_pkg::node_t                    head_in;
  swm_pkg::node_t                    root;
  logic [WINDOW_MAX-1:0]             alive_vec;

  assign accept = in_valid && !in_stall;
  assign clear  = in_first_sample || start_pending_r;

  // Window size in force, with zero read as one and oversize read as the chain length.
  assign win_raw = CW'(window_size_r);
  always_comb begin
    w_eff = win_raw;
    if (win_raw == '0) begin
      w_eff = ONE_CW;
    end else if (win_raw > WMAX_CW) begin
      w_eff = WMAX_CW;
    end
  end

  // Samples taken in this sequence, saturating at the chain length.
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (clear) begin
        fill_nxt = ONE_FILL;
      end else if (fill_r != WMAX_FILL) begin
        fill_nxt = fill_r + ONE_FILL;
      end
    end
  end

  // The newest cell always takes the sample; only older cells are cleared.
  assign ctl_head.shift = accept;
  assign ctl_head.clear = 1'b0;
  assign ctl_body.shift = accept;
  assign ctl_body.clear = clear;

  assign head_in.alive = 1'b1;
  assign head_in.value = in_sample;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    swm_cell #(
      .IDX (k),
      .AW  (CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    ((k == 0) ? ctl_head : ctl_body),
      .window (w_eff),
      .sample (in_sample),
      .prev_i ((k == 0) ? head_in : cell_q[(k == 0) ? 0 : k - 1]),
      .cell_o (cell_q[k])
    );
    assign alive_vec[k] = cell_q[k].alive;
  end

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < WINDOW_MAX) begin : g_real
      assign leaf[k] = cell_q[k];
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  swm_tree #(
    .LEAVES (LEAVES)
  ) u_tree (
    .clk    (clk),
    .leaf_i (leaf),
    .root_o (root)
  );

  // The tree root is settled once the settle counter, loaded with the tree depth when the chain shifted, reaches zero.
  assign finish   = (state_r == ST_BUSY) && (cnt_r == '0) &&
                    (!pend_emit_r || !out_valid_r || !out_stall);
  assign out_load = finish && pend_emit_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
          cnt_nxt   = LVLS_CNT;
        end
      end
      ST_BUSY: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      window_size_r   <= swm_pkg::WINDOW_SIZE_RESET;
      fill_r          <= '0;
      start_pending_r <= 1'b1;
      pend_emit_r     <= 1'b0;
      pend_last_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        window_size_r <= cfg_wdata;
      end
      if (accept) begin
        start_pending_r <= in_last_sample;
        pend_emit_r     <= CW'(fill_nxt) >= w_eff;
        pend_last_r     <= in_last_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_window_max_r  <= root.value;
      out_last_result_r <= pend_last_r;
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_window_max  = out_window_max_r;
  assign out_last_result = out_last_result_r;

  // The newest sample is always a candidate right after it enters.
  a_head_alive: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> alive_vec[0])
    else $error("newest cell not alive after a beat");

  // A cleared sequence holds exactly one candidate after its first beat.
  a_clear_one: assert property (@(posedge clk) disable iff (!rst_n)
    accept && clear |=> $countones(alive_vec) == 1)
    else $error("queue not reduced to one candidate on a new sequence");

  // A result is only ever taken from a tree root that found a candidate.
  a_root_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> root.alive)
    else $error("result loaded from an empty tree root");

  // The settle counter never runs past the tree depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LVLS_CNT)
    else $error("settle counter out of range");

  // A pending result waiting on a stalled output keeps the input side closed.
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) && (cnt_r == '0) && pend_emit_r && out_valid_r && out_stall
      |=> state_r == ST_BUSY)
    else $error("pending result dropped while output stalled");

endmodule

### sv/swm_cell.sv
// One chain cell: holds the sample of one fixed age and its candidate flag.
`timescale 1ns / 1ps

module swm_cell #(
  parameter int IDX = 0,
  parameter int AW  = swm_pkg::WIN_SIZE_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  swm_pkg::cell_ctl_t               ctl,
  input  logic [AW-1:0]                    window,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  swm_pkg::node_t                   prev_i,
  output swm_pkg::node_t                   cell_o
);

  localparam logic [AW-1:0] AGE = AW'(IDX);

  logic                              alive_r;
  logic                              alive_nxt;
  logic signed [swm_pkg::DATA_W-1:0] val_r;
  logic signed [swm_pkg::DATA_W-1:0] val_nxt;

  // A sample stays a candidate while it is inside the window and no newer
  // sample is strictly larger; equal values survive.
  always_comb begin
    alive_nxt = alive_r;
    val_nxt   = val_r;
    if (ctl.shift) begin
      val_nxt   = prev_i.value;
      alive_nxt = prev_i.alive && (AGE < window) && !(prev_i.value < sample) && !ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
    end else begin
      alive_r <= alive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign cell_o.alive = alive_r;
  assign cell_o.value = val_r;

endmodule

### sv/swm_tree.sv
// Registered selection tree that finds the oldest live candidate of the chain.
`timescale 1ns / 1ps

module swm_tree #(
  parameter int LEAVES = 64
) (
  input  logic           clk,
  input  swm_pkg::node_t leaf_i [LEAVES],
  output swm_pkg::node_t root_o
);

  // Heap order: node i has children 2i and 2i+1; the higher child covers older cells.
  swm_pkg::node_t node_r [1:LEAVES-1];

  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    if (2 * i >= LEAVES) begin : g_from_leaf
      always_ff @(posedge clk) begin
        node_r[i] <= swm_pkg::node_pick(leaf_i[2*i-LEAVES], leaf_i[2*i+1-LEAVES]);
      end
    end else begin : g_from_node
      always_ff @(posedge clk) begin
        node_r[i] <= swm_pkg::node_pick(node_r[2*i], node_r[2*i+1]);
      end
    end
  end

  assign root_o = node_r[1];

endmodule

### dv/sliding_window_max_top_tb.sv
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 1ps

module sliding_window_max_top_tb;

  localparam int WIN_MAX      = swm_pkg::WINDOW_MAX_DEF;
  // A sample that yields no result can still be in flight in the block when the
  // last result arrives, so every pause before a register write, and the one at
  // the end, gives it time to drain out of the block.
  localparam int SETTLE_CYCLES = 32;
  // Cycles without any accepted beat or register write before the run is abandoned.
  // The slowest correct beat combines the largest send gap, a pass through the block
  // and the longest result stall, so this is many times the worst case.
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_SAMPLES = 100;
  localparam int NUM_PHASES    = 10;

  // One sample beat as the driver sends it, plus the idle cycles in front of it.
  typedef struct {
    logic signed [swm_pkg::DATA_W-1:0] sample;
    logic                              first_flag;
    logic                              last_flag;
    int unsigned                       gap;
  } sample_beat_t;

  // One result beat as the block should give it.
  typedef struct {
    logic signed [swm_pkg::DATA_W-1:0] max_value;
    logic                              last_flag;
  } window_result_t;

  // One entry of the candidate queue kept by the predictor.
  typedef struct {
    logic signed [swm_pkg::DATA_W-1:0] value;
    int unsigned                       age;
  } candidate_t;

  logic                              clk;
  logic                              rst_n           = 1'b0;
  logic                              in_valid        = 1'b0;
  logic                              in_stall;
  logic signed [swm_pkg::DATA_W-1:0] in_sample       = '0;
  logic                              in_first_sample = 1'b0;
  logic                              in_last_sample  = 1'b0;
  logic                              out_valid;
  logic                              out_stall       = 1'b0;
  logic signed [swm_pkg::DATA_W-1:0] out_window_max;
  logic                              out_last_result;
  logic                              cfg_we          = 1'b0;
  logic [swm_pkg::WIN_SIZE_W-1:0]    cfg_wdata       = '0;

  sliding_window_max_top #(
    .WINDOW_MAX (WIN_MAX)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_first_sample (in_first_sample),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_max  (out_window_max),
    .out_last_result (out_last_result),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Samples waiting to be sent, and window maxima waiting to come back.
  sample_beat_t   pending_beats[$];
  window_result_t expected_maxima[$];

  // Predictor state: candidate queue (oldest first), samples in the current
  // sequence, whether the next sample opens a new sequence, and the window register.
  candidate_t                     cands[$];
  int unsigned                    seq_fill      = 0;
  bit                             new_seq_due   = 1'b1;
  logic [swm_pkg::WIN_SIZE_W-1:0] window_reg    = swm_pkg::WINDOW_SIZE_RESET;

  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned results_seen     = 0;
  int unsigned last_results     = 0;
  int unsigned windows_set      = 0;
  int unsigned error_count      = 0;
  int unsigned quiet_cycles     = 0;
  // Idle and stall are switched off per phase to get stretches at full rate.
  bit          send_idle_on     = 1'b1;
  bit          take_idle_on     = 1'b1;

  // Window length that the block actually uses for a register value.
  function automatic int unsigned eff_window(input logic [swm_pkg::WIN_SIZE_W-1:0] w);
    if (w == 0) return 1;
    if (w > WIN_MAX) return WIN_MAX;
    return 32'(w);
  endfunction

  // Advance the candidate queue by one accepted sample and queue the window maximum
  // it produces, if the sequence already holds a full window.
  task automatic track_window_max(input sample_beat_t b);
    int unsigned    w;
    candidate_t     fresh;
    window_result_t r;
    w = eff_window(window_reg);
    if (b.first_flag || new_seq_due) begin
      cands.delete();
      seq_fill = 0;
    end
    foreach (cands[i]) begin
      if (cands[i].age < WIN_MAX) cands[i].age = cands[i].age + 1;
    end
    // Candidates that have aged out leave from the front.
    while (cands.size() != 0 && cands[0].age >= w) void'(cands.pop_front());
    // Strictly smaller candidates can never win again; equal ones are kept.
    while (cands.size() != 0 && cands[cands.size()-1].value < b.sample)
      void'(cands.pop_back());
    if (cands.size() < WIN_MAX) begin
      fresh.value = b.sample;
      fresh.age   = 0;
      cands.push_back(fresh);
    end
    if (seq_fill < WIN_MAX) seq_fill++;
    new_seq_due = b.last_flag;
    if (seq_fill >= w) begin
      r.max_value = cands[0].value;
      r.last_flag = b.last_flag;
      expected_maxima.push_back(r);
    end
  endtask

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endtask

  // Driver: presents queued samples, waiting each one's gap before raising valid.
  // in_valid gets at most one assignment per edge, so back-to-back beats keep it high.
  always @(posedge clk) begin : drive_samples
    sample_beat_t cur_beat;
    int unsigned  gap_wait;
    bit           can_load;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_sample       <= '0;
      in_first_sample <= 1'b0;
      in_last_sample  <= 1'b0;
      gap_wait = 0;
    end else begin
      can_load = !in_valid;
      if (in_valid && !in_stall) begin
        track_window_max(cur_beat);
        samples_accepted++;
        can_load = 1'b1;
      end
      if (can_load) begin
        if (pending_beats.size() != 0 && gap_wait >= pending_beats[0].gap) begin
          cur_beat = pending_beats.pop_front();
          gap_wait = 0;
          in_valid        <= 1'b1;
          in_sample       <= cur_beat.sample;
          in_first_sample <= cur_beat.first_flag;
          in_last_sample  <= cur_beat.last_flag;
        end else begin
          if (pending_beats.size() != 0) gap_wait++;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result beat against the oldest expected maximum. Each
  // result is held off for a drawn number of cycles in which it is on offer, so
  // the stall lands on results that are already waiting at the output register.
  always @(posedge clk) begin : collect_results
    window_result_t want;
    int unsigned    stall_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_last_result) last_results++;
        if (expected_maxima.size() == 0) begin
          note_error($sformatf("Unexpected result beat: max %0d last %0b",
                               out_window_max, out_last_result));
        end else begin
          want = expected_maxima.pop_front();
          if (want.max_value !== out_window_max || want.last_flag !== out_last_result)
            note_error($sformatf(
              "Result %0d mismatch: expected max %0d last %0b, got max %0d last %0b",
              results_seen, want.max_value, want.last_flag,
              out_window_max, out_last_result));
        end
        stall_left = take_idle_on ? $urandom_range(0, 3) : 0;
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Anything that moves resets the quiet counter.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_beat(input logic signed [swm_pkg::DATA_W-1:0] s, input logic f,
                           input logic l);
    sample_beat_t b;
    b.sample     = s;
    b.first_flag = f;
    b.last_flag  = l;
    b.gap        = send_idle_on ? $urandom_range(0, 3) : 0;
    pending_beats.push_back(b);
    samples_queued++;
  endtask

  // Sample content for one sequence. Falling runs keep every sample a candidate and
  // fill the queue to the window length; small ranges give many equal values.
  function automatic logic signed [swm_pkg::DATA_W-1:0] pick_sample(input int mode,
                                                                     input int idx);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: return idx * 3 - 100;
      3: return 1000 - idx * 7;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // One sequence of samples. Noisy sequences get stray first and last flags.
  task automatic queue_sequence(input int unsigned len, input bit with_first,
                                input bit close, input bit noisy);
    int   mode;
    logic f;
    logic l;
    mode = $urandom_range(0, 4);
    for (int k = 0; k < len; k++) begin
      f = (k == 0 && with_first) || (noisy && $urandom_range(0, 15) == 0);
      l = (k == len - 1 && close) || (noisy && $urandom_range(0, 15) == 0);
      push_beat(pick_sample(mode, k), f, l);
    end
  endtask

  // Wait until every queued sample is taken and every result is back, then let
  // any sample that produced no result drain out of the block.
  task automatic settle_block();
    while (samples_accepted != samples_queued || expected_maxima.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [swm_pkg::WIN_SIZE_W-1:0] w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    window_reg = w;
    windows_set++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [swm_pkg::WIN_SIZE_W-1:0] window_plan[NUM_PHASES];
    logic [swm_pkg::WIN_SIZE_W-1:0] w_reg;
    int unsigned                    w;
    int unsigned                    phase_start;
    int unsigned                    len;
    int unsigned                    r;
    int unsigned                    n;
    bit                             carry_open;
    bit                             with_first;
    // Extremes first (one, two, the largest, zero, out of range), then ordinary sizes;
    // the last two phases take a random register value.
    window_plan = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd65, 7'd5, 7'd16, 7'd0, 7'd0};
    carry_open = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset window of three. The first sample carries no
    // first flag, so it relies on the block starting a sequence out of reset.
    push_beat(5, 1'b0, 1'b0);
    push_beat(32'sh7fff_ffff, 1'b0, 1'b0);
    push_beat(32'sh8000_0000, 1'b0, 1'b0);
    push_beat(-1, 1'b0, 1'b0);
    push_beat(-1, 1'b0, 1'b0);               // equal values stay in the queue
    push_beat(-1, 1'b0, 1'b0);
    push_beat(32'sh8000_0000, 1'b0, 1'b1);
    push_beat(10, 1'b0, 1'b0);               // new sequence after a last beat
    push_beat(20, 1'b0, 1'b0);
    push_beat(30, 1'b0, 1'b0);
    push_beat(0, 1'b1, 1'b0);                // first flag cuts the running sequence
    push_beat(0, 1'b0, 1'b1);                // too short for any result
    push_beat(42, 1'b1, 1'b1);               // first and last on one beat
    push_beat(32'sh8000_0000, 1'b1, 1'b0);
    push_beat(32'sh8000_0000, 1'b0, 1'b0);
    push_beat(32'sh8000_0000, 1'b0, 1'b0);
    push_beat(32'sh7fff_ffff, 1'b0, 1'b0);
    push_beat(3, 1'b0, 1'b0);
    push_beat(2, 1'b0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      w_reg = (p >= 8) ? 7'($urandom_range(0, 127)) : window_plan[p];
      set_window(w_reg);
      w = eff_window(w_reg);
      send_idle_on = (p % 4 != 1);
      take_idle_on = (p % 4 != 2);
      phase_start  = samples_queued;
      while (samples_queued - phase_start < PHASE_SAMPLES) begin
        r          = $urandom_range(0, 9);
        with_first = carry_open ? 1'b0 : 1'($urandom_range(0, 1));
        if (r < 8) begin
          // Mostly well-formed sequences long enough to give many results.
          len = w + $urandom_range(0, w / 2 + 10);
          queue_sequence(len, with_first, 1'b1, r >= 6);
        end else if (r == 8) begin
          len = (w > 1) ? $urandom_range(1, w - 1) : 1;
          queue_sequence(len, with_first, 1'b1, 1'b0);
        end else begin
          queue_sequence(1, !carry_open, 1'b1, 1'b0);
        end
        carry_open = 1'b0;
      end
      // Sometimes leave the sequence open so the next window size applies to it
      // mid-sequence.
      if ($urandom_range(0, 1) == 1) begin
        queue_sequence($urandom_range(1, 8), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        carry_open = 1'b1;
      end
    end

    while (samples_accepted != samples_queued) @(posedge clk);
    n = 0;
    while (n < QUIET_LIMIT && expected_maxima.size() != 0) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_maxima.size() != 0)
      note_error($sformatf("%0d expected results never arrived", expected_maxima.size()));

    $display("Sent %0d samples under %0d window settings plus the reset setting.",
             samples_accepted, windows_set);
    $display("Checked %0d window maxima, %0d of them closing a sequence; %0d errors.",
             results_seen, last_results, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/swm_pkg.sv
sv/swm_cell.sv
sv/swm_tree.sv
sv/sliding_window_max_top.sv
dv/sliding_window_max_top_tb.sv
